@@ rtl/sha512_pkg.sv @@
// Package for the SHA-512 hash engine: state type, constants and round functions.
// No dependencies; used by all rtl modules.
`default_nettype none
package sha512_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_OUTPUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_word;   // store input word, track fill and length
    logic       start_blk;   // copy hash into working vars, round counter 0
    logic       do_round;    // one compression round
    logic       update_hash; // add working vars into hash
    logic       out_shift;   // rotate hash for digest output
    logic       reset_hash;  // reload initial hash, clear counters
  } ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic       round_done;  // round 79 in progress
    logic       block_full;  // a full block is ready to compress
    logic       final_more;  // a further final block follows this one
    logic       out_done;    // last digest word being sent
  } stat_t;

  localparam logic [63:0] H_INIT [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

@@ rtl/sha512_hash_engine_core.sv @@
// SHA-512 hash engine, top level: joins the controller and the datapath.
// Depends on sha512_pkg, sha512_ctrl and sha512_dp.
//
// The engine hashes a message given as big-endian 64-bit words. Each input
// transfer carries one word, its count of valid leading bytes (used only on
// the last word, values above eight count as eight) and a last-word flag.
// Words are taken one per cycle while the engine is idle; the sixteenth word
// of a block, and every last word, start a compression that runs one round
// per cycle from a 16-word sliding schedule window, 80 rounds followed by the
// hash update. On the last word the padding and the 64-bit bit length are
// built in place; when they do not fit, a second block follows.
// The digest then leaves as eight output transfers, word 0 first, with its
// index and a flag on word 7, after which the initial hash is reloaded.
// Input is not accepted during compression or while the digest is emitted.
`default_nettype none
module sha512_hash_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // [63:0] message_word, [67:64] valid_bytes
  input  wire logic        s_axis_tlast,   // last_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] digest_word, [66:64] digest_index
  output logic             m_axis_tlast    // digest_last
);

  sha512_pkg::ctrl_t ctrl;
  sha512_pkg::stat_t stat;
  logic in_fire, out_fire;
  logic [63:0] dword;
  logic [2:0]  didx;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  sha512_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .in_last_i  (s_axis_tlast),
    .out_fire_i (out_fire),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  sha512_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i   (ctrl),
    .word_i   (s_axis_tdata[63:0]),
    .vbytes_i (s_axis_tdata[67:64]),
    .last_i   (s_axis_tlast),
    .stat_o   (stat),
    .digest_o (dword),
    .index_o  (didx),
    .dlast_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, didx, dword};

endmodule
`default_nettype wire

@@ rtl/sha512_ctrl.sv @@
// Controller state machine of the SHA-512 hash engine.
// Depends on sha512_pkg.
`default_nettype none
module sha512_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_fire_i,
  input  wire logic             in_last_i,
  input  wire logic             out_fire_i,
  input  wire sha512_pkg::stat_t stat_i,
  output sha512_pkg::ctrl_t     ctrl_o,
  output logic                  in_ready_o,
  output logic                  out_valid_o
);

  sha512_pkg::state_e state_q, state_d;
  logic final_q, final_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha512_pkg::ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    case (state_q)
      sha512_pkg::ST_IDLE: begin
        if (in_fire_i && (in_last_i || stat_i.block_full)) begin
          state_d = sha512_pkg::ST_ROUND;
          final_d = in_last_i;
        end
      end
      sha512_pkg::ST_ROUND: begin
        if (stat_i.round_done) state_d = sha512_pkg::ST_UPDATE;
      end
      sha512_pkg::ST_UPDATE: begin
        if (final_q && stat_i.final_more) state_d = sha512_pkg::ST_ROUND;
        else if (final_q) state_d = sha512_pkg::ST_OUTPUT;
        else state_d = sha512_pkg::ST_IDLE;
      end
      sha512_pkg::ST_OUTPUT: begin
        if (out_fire_i && stat_i.out_done) begin
          state_d = sha512_pkg::ST_IDLE;
          final_d = 1'b0;
        end
      end
      default: state_d = sha512_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      sha512_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        ctrl_o.load_word = in_fire_i;
        ctrl_o.start_blk = in_fire_i && (in_last_i || stat_i.block_full);
      end
      sha512_pkg::ST_ROUND:  ctrl_o.do_round = 1'b1;
      sha512_pkg::ST_UPDATE: begin
        ctrl_o.update_hash = 1'b1;
        ctrl_o.start_blk   = final_q && stat_i.final_more;
      end
      sha512_pkg::ST_OUTPUT: begin
        out_valid_o       = 1'b1;
        ctrl_o.out_shift  = out_fire_i;
        ctrl_o.reset_hash = out_fire_i && stat_i.out_done;
      end
      default: ;
    endcase
  end

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input ready while emitting");
  a_round_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha512_pkg::ST_ROUND && stat_i.round_done) |=>
    state_q == sha512_pkg::ST_UPDATE) else $error("round end missed");
  a_out_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> final_q) else $error("output outside final block");

endmodule
`default_nettype wire

@@ rtl/sha512_dp.sv @@
// Datapath of the SHA-512 hash engine: block buffer, schedule window, rounds, hash.
// Depends on sha512_pkg.
`default_nettype none
module sha512_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sha512_pkg::ctrl_t ctrl_i,
  input  wire logic [63:0]       word_i,
  input  wire logic [3:0]        vbytes_i,
  input  wire logic              last_i,
  output sha512_pkg::stat_t      stat_o,
  output logic [63:0]            digest_o,
  output logic [2:0]             index_o,
  output logic                   dlast_o
);

  logic [63:0] buf_q [16];
  logic [63:0] w_q [16];
  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [3:0]  pos_q;
  logic [63:0] total_q;
  logic [6:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        second_q;   // a second final block (length, and padding byte if needed) is pending
  logic        spill_q;
  // The padding byte goes into the second block only when a full last word
  // landed in slot 15 of the first one; pad_slot15_q remembers that case.
  logic        pad_slot15_q;

  // Per-word input handling for the last word.
  logic [3:0]  vb;
  logic [63:0] keep, padded, total_add;
  logic        full8;
  logic        spill_now;
  always_comb begin
    vb    = (vbytes_i > 4'd8) ? 4'd8 : vbytes_i;
    full8 = !last_i || (vb == 4'd8);
    keep  = (vb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {vb, 3'b000});
    padded = (word_i & keep) | (64'h8000000000000000 >> {vb, 3'b000});
    total_add = total_q + (last_i ? {60'd0, vb} : 64'd8);
    // The length does not fit behind the padding byte in this block.
    spill_now = full8 ? (pos_q >= 4'd13) : (pos_q >= 4'd14);
  end

  assign stat_o.block_full = (pos_q == 4'd15) && !last_i;

  // Schedule word for this round and next window word.
  logic [63:0] wt, s0, s1, wnew;
  logic [63:0] big0, big1, ch, maj, t1, t2;
  always_comb begin
    wt   = w_q[0];
    s0   = sha512_pkg::ror64(w_q[1], 1) ^ sha512_pkg::ror64(w_q[1], 8) ^ (w_q[1] >> 7);
    s1   = sha512_pkg::ror64(w_q[14], 19) ^ sha512_pkg::ror64(w_q[14], 61) ^ (w_q[14] >> 6);
    wnew = s1 + w_q[9] + s0 + w_q[0];
    big1 = sha512_pkg::ror64(v_q[4], 14) ^ sha512_pkg::ror64(v_q[4], 18)
         ^ sha512_pkg::ror64(v_q[4], 41);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + sha512_pkg::ROUND_K[rnd_q] + wt;
    big0 = sha512_pkg::ror64(v_q[0], 28) ^ sha512_pkg::ror64(v_q[0], 34)
         ^ sha512_pkg::ror64(v_q[0], 39);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  // Hash after the current block; a second final block starts from it.
  logic [63:0] hsum [8];
  always_comb begin
    for (int i = 0; i < 8; i++) hsum[i] = h_q[i] + v_q[i];
  end

  assign stat_o.round_done = (rnd_q == 7'd79);
  assign stat_o.final_more = second_q;
  assign stat_o.out_done   = (oidx_q == 3'd7);
  assign digest_o = h_q[0];
  assign index_o  = oidx_q;
  assign dlast_o  = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_slot15_q <= 1'b0;
    else if (ctrl_i.load_word && last_i) pad_slot15_q <= full8 && (pos_q == 4'd15);
  end

  // Control of final block layout is done with a simple clear-and-fill.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      total_q  <= '0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      second_q <= 1'b0;
      spill_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::H_INIT[i];
    end else begin
      if (ctrl_i.load_word) begin
        total_q <= total_add;
        if (!last_i) begin
          buf_q[pos_q] <= word_i;
          pos_q <= pos_q + 4'd1;
        end
      end
      if (ctrl_i.start_blk) begin
        rnd_q <= '0;
        for (int i = 0; i < 8; i++) v_q[i] <= ctrl_i.update_hash ? hsum[i] : h_q[i];
        if (ctrl_i.load_word && last_i) begin
          // First final block built from buffer, last word and padding.
          for (int i = 0; i < 16; i++) begin
            if (i < int'(pos_q)) w_q[i] <= buf_q[i];
            else if (i == int'(pos_q)) w_q[i] <= full8 ? word_i : padded;
            else if (full8 && i == int'(pos_q) + 1) w_q[i] <= 64'h8000000000000000;
            else if (i == 15 && !spill_now) w_q[i] <= {total_add[60:0], 3'b000};
            else w_q[i] <= 64'd0;
          end
          spill_q  <= spill_now;
          second_q <= spill_now;
          pos_q    <= '0;
        end else if (ctrl_i.load_word) begin
          for (int i = 0; i < 15; i++) w_q[i] <= buf_q[i];
          w_q[15] <= word_i;
        end else begin
          // Second final block: zeros and the bit length, with padding byte if the first was full.
          for (int i = 0; i < 16; i++) begin
            if (i == 0 && pad_slot15_q) w_q[i] <= 64'h8000000000000000;
            else if (i == 15) w_q[i] <= {total_q[60:0], 3'b000};
            else w_q[i] <= 64'd0;
          end
          second_q <= 1'b0;
        end
      end else if (ctrl_i.do_round) begin
        rnd_q <= rnd_q + 7'd1;
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
        w_q[15] <= wnew;
        v_q[0] <= t1 + t2;
        v_q[1] <= v_q[0];
        v_q[2] <= v_q[1];
        v_q[3] <= v_q[2];
        v_q[4] <= v_q[3] + t1;
        v_q[5] <= v_q[4];
        v_q[6] <= v_q[5];
        v_q[7] <= v_q[6];
      end
      if (ctrl_i.update_hash) begin
        for (int i = 0; i < 8; i++) h_q[i] <= hsum[i];
      end
      if (ctrl_i.reset_hash) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::H_INIT[i];
        total_q <= '0;
        pos_q   <= '0;
        oidx_q  <= '0;
        spill_q <= 1'b0;
      end else if (ctrl_i.out_shift) begin
        oidx_q <= oidx_q + 3'd1;
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i + 1];
        h_q[7] <= h_q[0];
      end
    end
  end

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.do_round |-> rnd_q <= 7'd79) else $error("round counter overrun");
  a_second_only_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> spill_q) else $error("second block without spill");
  a_out_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.reset_hash |-> oidx_q == 3'd7) else $error("digest reset early");

endmodule
`default_nettype wire

@@ tb/sv/tb_sha512_hash_engine_core.sv @@
// Testbench for the SHA-512 hash engine core: streams random and directed messages
// and checks every digest word against a behavioral SHA-512 model.
// Depends on the sha512_hash_engine_core rtl.
`timescale 1ns / 1ps
module tb_sha512_hash_engine_core;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] KTAB [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // [63:0] message_word, [67:64] valid_bytes
  logic        s_axis_tlast;   // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [63:0] digest_word, [66:64] digest_index
  logic        m_axis_tlast;   // digest_last

  sha512_hash_engine_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Model state of the hashing engine.
  logic [63:0] mdl_hash [8];
  logic [63:0] mdl_blk  [16];
  int unsigned mdl_pos;        // next word slot in the block, 0..15
  logic [63:0] mdl_bytes;      // message byte count, wraps at 2^64

  msg_word_t    send_q   [$];
  digest_word_t digest_q [$];
  int unsigned  n_errors;
  int unsigned  n_sent;
  int unsigned  n_digests;
  int unsigned  n_msgs;
  bit           calm;          // no idling near the end of the run
  bit           hold_until_empty;

  function automatic logic [63:0] rr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_blk();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = mdl_blk[t];
    for (int t = 16; t < 80; t++)
      w[t] = (rr(w[t-2], 19) ^ rr(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7] +
             (rr(w[t-15], 1) ^ rr(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = mdl_hash[i];
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
      t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) mdl_hash[i] += v[i];
  endtask

  task automatic store_word(input logic [63:0] w);
    mdl_blk[mdl_pos] = w;
    mdl_pos++;
    if (mdl_pos == 16) begin
      compress_blk();
      mdl_pos = 0;
    end
  endtask

  // Advances the model by one accepted word and queues any digest it finishes.
  task automatic hash_word(input msg_word_t it);
    int unsigned nb;
    logic [63:0] pad;
    digest_word_t d;
    if (!it.last) begin
      mdl_bytes += 8;
      store_word(it.word);
      return;
    end
    nb = (it.nbytes > 8) ? 8 : it.nbytes;
    mdl_bytes += nb;
    if (nb == 8) begin
      store_word(it.word);
      pad = 64'h80 << 56;
    end else begin
      pad = ((nb == 0) ? 64'h0 : (it.word & (~64'h0 << (64 - 8 * nb)))) |
            (64'h80 << (56 - 8 * nb));
    end
    mdl_blk[mdl_pos] = pad;
    mdl_pos++;
    // The length field does not fit after the pad byte: spill into a new block.
    if (mdl_pos > 14) begin
      for (int i = mdl_pos; i < 16; i++) mdl_blk[i] = '0;
      compress_blk();
      mdl_pos = 0;
    end
    for (int i = mdl_pos; i < 15; i++) mdl_blk[i] = '0;
    mdl_blk[15] = mdl_bytes << 3;
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      d.word  = mdl_hash[i];
      d.index = i[2:0];
      d.last  = (i == 7);
      digest_q.push_back(d);
    end
    for (int i = 0; i < 8; i++) mdl_hash[i] = IV[i];
    mdl_pos   = 0;
    mdl_bytes = '0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_item(input logic [63:0] w, input logic [3:0] nb, input logic l);
    msg_word_t it;
    it.word = w; it.nbytes = nb; it.last = l;
    send_q.push_back(it);
  endtask

  // A message of n full words followed by a closing word.
  task automatic add_msg(input int n, input logic [3:0] nb);
    for (int i = 0; i < n; i++) add_item(rnd64(), 4'($urandom), 1'b0);
    add_item(rnd64(), nb, 1'b1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stimulus generation and the end-of-run decision.
  initial begin
    int k;
    for (int i = 0; i < 8; i++) mdl_hash[i] = IV[i];
    mdl_pos = 0; mdl_bytes = '0;
    n_errors = 0; n_sent = 0; n_digests = 0; n_msgs = 0;
    calm = 1'b0; hold_until_empty = 1'b0;
    rst_ni = 1'b0;

    // Directed part: empty message, several valid counts including above eight,
    // all-ones and all-zero words, pad spill at slots 14 and 15, a full block.
    add_item(64'h0, 4'd0, 1'b1);
    add_item(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
    add_item(64'h6162_6300_0000_0000, 4'd3, 1'b1);
    add_item(64'hffff_ffff_ffff_ffff, 4'd1, 1'b0);
    add_item(64'h0123_4567_89ab_cdef, 4'd7, 1'b1);
    add_msg(13, 4'd8);
    add_msg(14, 4'd0);
    add_msg(15, 4'd9);
    for (int i = 0; i < 16; i++) add_item(rnd64(), 4'd8, 1'b0);
    add_item(64'hffff_ffff_ffff_ffff, 4'd5, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random part: mostly short messages so digests are frequent, a few long.
    k = 0;
    while (k < 410) begin
      int n, nb;
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 16);
      nb = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      add_msg(n, 4'(nb));
      k += n + 1;
      n_msgs++;
      // Once, hold the sender until the engine has drained all digests.
      if (k > 200 && !hold_until_empty) begin
        hold_until_empty = 1'b1;
        wait (send_q.size() == 0 && digest_q.size() == 0);
      end
    end

    // The tail of the run goes without idling on either side.
    wait (send_q.size() <= 60);
    calm = 1'b1;

    wait (send_q.size() == 0 && !s_axis_tvalid);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Hashed %0d random messages plus directed cases; %0d words sent, %0d digests.",
             n_msgs, n_sent, n_digests);
    if (n_errors == 0 && digest_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Driver: presents queued words, with random idle bursts.
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    msg_word_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.word = s_axis_tdata[63:0]; it.nbytes = s_axis_tdata[67:64]; it.last = s_axis_tlast;
        hash_word(it);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          src_gap       <= $urandom_range(1, 16) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() != 0) begin
          it = send_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'h0, it.nbytes, it.word};
          s_axis_tlast  <= it.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order digest checking.
  int unsigned snk_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t got, exp_d;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.word = m_axis_tdata[63:0]; got.index = m_axis_tdata[66:64]; got.last = m_axis_tlast;
        n_digests += got.last;
        if (digest_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("Unexpected digest word %h idx %0d", got.word, got.index);
        end else begin
          exp_d = digest_q.pop_front();
          if (got !== exp_d) begin
            n_errors++;
            if (n_errors <= 10)
              $display("Digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d", exp_d.word,
                       exp_d.index, exp_d.last, got.word, got.index, got.last);
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap       <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_gap       <= $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("Timeout with %0d digest words outstanding.", digest_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
